// ===== rtl/core/gbfs_pkg.sv =====
// Shared types and constants for the grid breadth-first search unit.
// No dependencies.
package gbfs_pkg;

    localparam int unsigned CFG_ROWS = 0;
    localparam int unsigned CFG_COLS = 1;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned PATH_W = 15;
    localparam logic [PATH_W-1:0] PATH_SAT = {PATH_W{1'b1}};

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CLEAR,
        CMD_SEED,
        CMD_POP,
        CMD_NEIGH
    } t_cmd;

    typedef struct packed {
        logic clear_done;
        logic queue_empty;
        logic at_target;
        logic neigh_last;
    } t_status;

endpackage

// ===== rtl/core/gbfs_ctrl.sv =====
// Controller state machine for the grid search unit.
// Depends on gbfs_pkg.
module gbfs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_operation,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output logic              o_found_set,
    output logic              o_res_load,
    output gbfs_pkg::t_cmd    o_cmd,
    input  gbfs_pkg::t_status i_status
);
    import gbfs_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CLEAR,
        S_SEED,
        S_POP,
        S_WAIT,
        S_NEIGH,
        S_DONE
    } t_state;

    t_state r_state;
    logic   r_out_valid;

    assign o_out_valid = r_out_valid;
    assign o_in_ready  = (r_state == S_IDLE) && !r_out_valid;

    always_comb begin
        o_cmd       = CMD_NONE;
        o_res_load  = 1'b0;
        o_found_set = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && o_in_ready && !i_operation) begin
                    o_cmd = CMD_LOAD;
                end
            end
            S_CLEAR: o_cmd = CMD_CLEAR;
            S_SEED:  o_cmd = CMD_SEED;
            S_POP: begin
                if (!i_status.queue_empty) begin
                    o_cmd = CMD_POP;
                end else begin
                    o_res_load = 1'b1;
                end
            end
            S_WAIT: begin
                if (i_status.at_target) begin
                    o_res_load  = 1'b1;
                    o_found_set = 1'b1;
                end
            end
            S_NEIGH: o_cmd = CMD_NEIGH;
            default: o_cmd = CMD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready && i_operation) begin
                        r_state <= S_CLEAR;
                    end
                end
                S_CLEAR: begin
                    if (i_status.clear_done) begin
                        r_state <= S_SEED;
                    end
                end
                S_SEED: r_state <= S_POP;
                S_POP: begin
                    if (i_status.queue_empty) begin
                        r_state     <= S_DONE;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (i_status.at_target) begin
                        r_state     <= S_DONE;
                        r_out_valid <= 1'b1;
                    end else begin
                        r_state <= S_NEIGH;
                    end
                end
                S_NEIGH: begin
                    if (i_status.neigh_last) begin
                        r_state <= S_POP;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== rtl/core/gbfs_dp.sv =====
// Datapath for the grid search unit: grid, seen map, queue and result.
// Depends on gbfs_pkg.
module gbfs_dp #(
    parameter int unsigned MAX_ROWS = 128,
    parameter int unsigned MAX_COLS = 128
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  gbfs_pkg::t_cmd            i_cmd,
    output gbfs_pkg::t_status         o_status,
    input  logic                      i_res_load,
    input  logic                      i_found_set,
    input  logic [6:0]                i_row,
    input  logic [6:0]                i_col,
    input  logic                      i_open,
    input  logic [7:0]                i_grid_rows,
    input  logic [7:0]                i_grid_cols,
    output logic                      o_found,
    output logic [gbfs_pkg::PATH_W-1:0] o_path_cells
);
    import gbfs_pkg::*;

    localparam int unsigned RW    = $clog2(MAX_ROWS);
    localparam int unsigned CW    = $clog2(MAX_COLS);
    localparam int unsigned AW    = RW + CW;
    localparam int unsigned CELLS = 1 << AW;
    localparam int unsigned DW    = AW + 1;
    localparam int unsigned QW    = AW + 1;
    localparam int unsigned SW    = (RW > CW ? RW : CW) + 1;

    logic          r_open_mem [CELLS];
    logic          r_seen_mem [CELLS];
    logic [AW+DW-1:0] r_queue [CELLS];

    logic [QW-1:0] r_head, r_tail;
    logic [AW-1:0] r_clr;
    logic [RW-1:0] r_cur_r;
    logic [CW-1:0] r_cur_c;
    logic [DW-1:0] r_cur_d;
    logic [1:0]    r_dir;
    logic [RW-1:0] r_nr;
    logic [CW-1:0] r_nc;
    logic          r_nvalid;
    logic [DW-1:0] r_nd;
    logic          r_nseen, r_nopen;
    logic [SW-1:0] w_rows, w_cols;
    logic          r_found;
    logic [PATH_W-1:0] r_path;

    always_comb begin
        w_rows = (i_grid_rows == 8'd0) ? SW'(1) :
                 (32'(i_grid_rows) > MAX_ROWS) ? SW'(MAX_ROWS) : SW'(i_grid_rows);
        w_cols = (i_grid_cols == 8'd0) ? SW'(1) :
                 (32'(i_grid_cols) > MAX_COLS) ? SW'(MAX_COLS) : SW'(i_grid_cols);
    end

    logic [RW-1:0] w_tr;
    logic [CW-1:0] w_tc;
    logic [RW-1:0] w_nr;
    logic [CW-1:0] w_nc;
    logic          w_nvalid;
    logic          w_load_ok;
    logic          w_push;
    logic [AW-1:0] w_pidx;

    assign w_tr = RW'(w_rows - SW'(1));
    assign w_tc = CW'(w_cols - SW'(1));
    assign w_load_ok = (32'(i_row) < MAX_ROWS) && (32'(i_col) < MAX_COLS);

    always_comb begin
        w_nr = r_cur_r;
        w_nc = r_cur_c;
        w_nvalid = 1'b0;
        case (r_dir)
            2'd0: begin
                w_nr = r_cur_r - RW'(1);
                w_nvalid = (r_cur_r != '0);
            end
            2'd1: begin
                w_nc = r_cur_c - CW'(1);
                w_nvalid = (r_cur_c != '0);
            end
            2'd2: begin
                w_nr = r_cur_r + RW'(1);
                w_nvalid = (SW'(r_cur_r) + SW'(1) < w_rows);
            end
            default: begin
                w_nc = r_cur_c + CW'(1);
                w_nvalid = (SW'(r_cur_c) + SW'(1) < w_cols);
            end
        endcase
    end

    logic r_neigh_act;

    assign w_push = r_nvalid && !r_nseen && r_nopen && (32'(r_tail) < CELLS);
    assign w_pidx = {r_nr, r_nc};

    assign o_status.clear_done  = (r_clr == AW'(CELLS - 1));
    assign o_status.queue_empty = (r_head == r_tail);
    assign o_status.at_target   = (r_cur_r == w_tr) && (r_cur_c == w_tc);
    assign o_status.neigh_last  = (r_dir == 2'd0) && r_neigh_act;

    always_ff @(posedge i_clk) begin
        if (i_cmd == CMD_LOAD && w_load_ok) begin
            r_open_mem[{RW'(i_row), CW'(i_col)}] <= i_open;
        end
        r_nopen <= r_open_mem[{w_nr, w_nc}];
        r_nseen <= r_seen_mem[{w_nr, w_nc}];
        if (i_cmd == CMD_CLEAR) begin
            r_seen_mem[r_clr] <= 1'b0;
        end else if (i_cmd == CMD_SEED) begin
            r_seen_mem['0] <= 1'b1;
        end else if (w_push) begin
            r_seen_mem[w_pidx] <= 1'b1;
        end
        if (i_cmd == CMD_SEED) begin
            r_queue['0] <= {AW'(0), DW'(1)};
        end else if (w_push) begin
            r_queue[r_tail[AW-1:0]] <= {w_pidx, r_nd};
        end
        if (i_cmd == CMD_POP) begin
            {r_cur_r, r_cur_c, r_cur_d} <= r_queue[r_head[AW-1:0]];
        end
        r_nr     <= w_nr;
        r_nc     <= w_nc;
        r_nd     <= r_cur_d + DW'(1);
        if (i_res_load) begin
            r_found <= i_found_set;
            if (!i_found_set) begin
                r_path <= '0;
            end else if (32'(r_cur_d) > 32'(PATH_SAT)) begin
                r_path <= PATH_SAT;
            end else begin
                r_path <= PATH_W'(r_cur_d);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_clr       <= '0;
            r_dir       <= '0;
            r_nvalid    <= 1'b0;
            r_neigh_act <= 1'b0;
        end else begin
            r_nvalid <= (i_cmd == CMD_NEIGH) && w_nvalid && !o_status.neigh_last;
            if (i_cmd == CMD_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end else begin
                r_clr <= '0;
            end
            if (i_cmd == CMD_SEED) begin
                r_head <= '0;
                r_tail <= QW'(1);
            end else begin
                if (i_cmd == CMD_POP) begin
                    r_head <= r_head + QW'(1);
                end
                if (w_push) begin
                    r_tail <= r_tail + QW'(1);
                end
            end
            if (i_cmd == CMD_NEIGH) begin
                r_dir       <= r_dir + 2'd1;
                r_neigh_act <= 1'b1;
            end else begin
                r_dir       <= '0;
                r_neigh_act <= 1'b0;
            end
        end
    end

    assign o_found      = r_found;
    assign o_path_cells = r_path;

endmodule

// ===== rtl/core/grid_bfs_shortest_path_unit.sv =====
// Grid breadth-first search unit, top level: config registers and wiring.
// Load words can follow back to back while the unit is idle and no result is pending.
// A run word takes a clearing pass over every seen bit (MAX_ROWS*MAX_COLS at the default
// sizes), a seed step, pop and wait steps per dequeued cell, a neighbor pass per cell that
// is not the target and a final step when the queue runs dry; the input is ready again
// the cycle after the result word is taken. Reset is synchronous, active low; grid sizes
// return to one by one. Depends on gbfs_pkg, gbfs_ctrl and gbfs_dp.
module grid_bfs_shortest_path_unit #(
    parameter int unsigned MAX_ROWS = 128,
    parameter int unsigned MAX_COLS = 128
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gbfs_pkg::CFG_IDX_W:0] i_cfg_index,
    input  logic [7:0]                  i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [6:0]                  i_row,
    input  logic [6:0]                  i_col,
    input  logic                        i_open,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic                        o_found,
    output logic [gbfs_pkg::PATH_W-1:0] o_path_cells
);
    import gbfs_pkg::*;

    logic [7:0] r_grid_rows, r_grid_cols;
    t_cmd       w_cmd;
    t_status    w_status;
    logic       w_res_load, w_found_set;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= 8'd1;
            r_grid_cols <= 8'd1;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == (CFG_IDX_W+1)'(CFG_ROWS)) begin
                r_grid_rows <= i_cfg_data;
            end else if (i_cfg_index == (CFG_IDX_W+1)'(CFG_COLS)) begin
                r_grid_cols <= i_cfg_data;
            end
        end
    end

    gbfs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_operation (i_operation),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_found_set (w_found_set),
        .o_res_load  (w_res_load),
        .o_cmd       (w_cmd),
        .i_status    (w_status)
    );

    gbfs_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_res_load   (w_res_load),
        .i_found_set  (w_found_set),
        .i_row        (i_row),
        .i_col        (i_col),
        .i_open       (i_open),
        .i_grid_rows  (r_grid_rows),
        .i_grid_cols  (r_grid_cols),
        .o_found      (o_found),
        .o_path_cells (o_path_cells)
    );

endmodule
